### src/dq_pkg.sv
// Package: sizes, operation codes and shared types of the double-ended queue.
package dq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Requested operation, as carried on the input channel.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_CLEAR      = 3'd4
  } func_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_PUSH_F = 3'd1,
    OP_PUSH_B = 3'd2,
    OP_POP_F  = 3'd3,
    OP_POP_B  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] data;
  } nbr_t;

endpackage

### src/dq_if.sv
// Interfaces: input and result channels of the double-ended queue.
interface dq_in_if;
  import dq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] back_value;
  logic                    is_empty;
  logic [CNT_W-1:0]        count;
  logic                    rejected;

  modport source (output valid, output front_value, output back_value, output is_empty,
                  output count, output rejected, input ready);
  modport sink   (input valid, input front_value, input back_value, input is_empty,
                  input count, input rejected, output ready);
endinterface

### src/dq_cell.sv
// One slot of the queue chain: a word and its valid bit, shifting with its neighbors.
module dq_cell import dq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  op_e                   op_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  nbr_t                  left_i,
  input  nbr_t                  right_i,
  output nbr_t                  self_o,
  output logic [DATA_WIDTH-1:0] back_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (op_i)
      OP_PUSH_F: begin
        valid_d = left_i.valid;
        data_d  = left_i.data;
      end
      OP_PUSH_B: begin
        // first free slot behind the tail takes the word
        if (!valid_q && left_i.valid) begin
          valid_d = 1'b1;
          data_d  = word_i;
        end
      end
      OP_POP_F: begin
        valid_d = right_i.valid;
        data_d  = right_i.data;
      end
      OP_POP_B:  valid_d = valid_q & right_i.valid;
      OP_CLEAR:  valid_d = 1'b0;
      default: begin
        valid_d = valid_q;
        data_d  = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign self_o = '{valid: valid_q, data: data_q};
  // tail cell drives its word onto the back bus
  assign back_o = (valid_q && !right_i.valid) ? data_q : '0;

endmodule

### src/double_ended_queue.sv
// Top level: bounded double-ended queue built as a chain of shifting cells.
//
// Usage
//   in_i  : one beat per operation: func (0 push front, 1 push back,
//           2 pop front, 3 pop back, 4 clear, others no-op) and value.
//   out_o : one beat per input beat: front and back entry after the
//           operation (0 when empty), is_empty, count and rejected.
//   A push into a full queue or a pop from an empty one leaves the queue
//   as it was and returns rejected = 1.
// Timing / throughput
//   The result beat appears in the cycle after the input beat is taken.
//   One operation per cycle is sustained while out_o.ready stays high:
//   the cell chain updates every slot at once, so there is no per-item iteration.
// Stalls
//   in_i.ready is high while no result is pending or the pending one is
//   taken in the same cycle; with out_o.ready low the block holds its
//   result and takes no new beat.
// Reset
//   rst_ni clears every valid bit, the count and the result flag; the
//   queue comes up empty and ready in the first cycle after reset.
module double_ended_queue import dq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  logic                  accept;
  logic                  full, empty;
  op_e                   op;
  logic                  rej_d, rej_q;
  logic [CNT_W-1:0]      count_d, count_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] back_word;

  nbr_t                  cell_st [DEPTH];
  nbr_t                  left_nb [DEPTH];
  nbr_t                  right_nb[DEPTH];
  logic [DATA_WIDTH-1:0] back_bus[DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      tail_flag;

  // A new beat goes in when the result slot is free or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign word       = in_i.value[DATA_WIDTH-1:0];

  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  // Decode the request into a chain command; rejected requests hold.
  always_comb begin
    op      = OP_HOLD;
    rej_d   = 1'b0;
    count_d = count_q;
    if (accept) begin
      case (func_e'(in_i.func))
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (full) begin
            rej_d = 1'b1;
          end else begin
            op      = (func_e'(in_i.func) == FN_PUSH_FRONT) ? OP_PUSH_F : OP_PUSH_B;
            count_d = count_q + CNT_W'(1);
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if (empty) begin
            rej_d = 1'b1;
          end else begin
            op      = (func_e'(in_i.func) == FN_POP_FRONT) ? OP_POP_F : OP_POP_B;
            count_d = count_q - CNT_W'(1);
          end
        end
        FN_CLEAR: begin
          op      = OP_CLEAR;
          count_d = '0;
        end
        default: begin
          op = OP_HOLD;
        end
      endcase
    end
  end

  // Cell chain: slot 0 is the front; the tail is the last valid slot.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_nb[i] = '{valid: 1'b1, data: word};
    end else begin : g_mid
      assign left_nb[i] = cell_st[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_nb[i] = '{valid: 1'b0, data: '0};
    end else begin : g_inner
      assign right_nb[i] = cell_st[i+1];
    end

    dq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .word_i  (word),
      .left_i  (left_nb[i]),
      .right_i (right_nb[i]),
      .self_o  (cell_st[i]),
      .back_o  (back_bus[i])
    );

    assign cell_valid[i] = cell_st[i].valid;
    assign tail_flag[i]  = cell_st[i].valid && !right_nb[i].valid;
  end

  // Only the tail cell drives a nonzero word, so an OR collects it.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | back_bus[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      rej_q       <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        rej_q       <= rej_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result beat reads the chain state left by the last operation.
  assign out_o.valid       = out_valid_q;
  assign out_o.front_value = cell_valid[0] ? VAL_W'($signed(cell_st[0].data)) : '0;
  assign out_o.back_value  = VAL_W'($signed(back_word));
  assign out_o.is_empty    = (count_q == '0);
  assign out_o.count       = count_q;
  assign out_o.rejected    = rej_q;

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(cell_valid)) == count_q)
    else $error("count register disagrees with occupied cells");

  a_single_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tail_flag))
    else $error("occupied cells are not contiguous");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !cell_valid[0])
    else $error("front cell valid disagrees with count");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rej_d) |=> (count_q == $past(count_q)) && $stable(cell_valid))
    else $error("rejected beat changed the queue");

  a_result_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted beat produced no result");
`endif

endmodule

### test/double_ended_queue_tb.sv
// Testbench: random and directed operations on the deque, results checked against a predictor.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  // Codes 5..7 are not operations; the block must report the queue unchanged.
  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_MID   = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

  localparam int ITEM_TARGET  = 400;
  localparam int SQUEEZE_AT   = 150;  // result count at which the long sink stall starts
  localparam int SQUEEZE_LEN  = 60;   // cycles of that stall
  localparam int DRAIN_CYCLES = 10;   // wait after the last result for stray beats
  // Longest legal quiet stretch is the sink stall plus a long source gap.
  localparam int IDLE_LIMIT   = 2000;

  // One result beat as seen on out_o.
  typedef struct packed {
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic                    is_empty;
    logic [CNT_W-1:0]        count;
    logic                    rejected;
  } deque_view_t;

  // Shadow deque: a ring of DEPTH slots, head index and entry count,
  // plus the results still owed by the block.
  class deque_scoreboard;
    logic [DATA_WIDTH-1:0] slot [DEPTH];
    int unsigned           head;
    int unsigned           held;
    deque_view_t           awaited [$];
    int unsigned           mismatches;

    function new();
      head       = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted operation and queue the view it should produce.
    function void apply_op(logic [FUNC_W-1:0] fn, logic signed [VAL_W-1:0] v);
      deque_view_t view;
      logic        rej;
      rej = 1'b0;
      case (fn)
        FN_PUSH_FRONT: begin
          if (held == DEPTH) begin
            rej = 1'b1;
          end else begin
            head       = (head == 0) ? DEPTH - 1 : head - 1;
            slot[head] = v[DATA_WIDTH-1:0];
            held++;
          end
        end
        FN_PUSH_BACK: begin
          if (held == DEPTH) begin
            rej = 1'b1;
          end else begin
            slot[(head + held) % DEPTH] = v[DATA_WIDTH-1:0];
            held++;
          end
        end
        FN_POP_FRONT: begin
          if (held == 0) begin
            rej = 1'b1;
          end else begin
            head = (head + 1) % DEPTH;
            held--;
          end
        end
        FN_POP_BACK: begin
          if (held == 0) rej = 1'b1;
          else held--;
        end
        FN_CLEAR: begin
          head = 0;
          held = 0;
        end
        default: ;
      endcase
      if (held == 0) begin
        view.front_value = '0;
        view.back_value  = '0;
        view.is_empty    = 1'b1;
      end else begin
        view.front_value = VAL_W'($signed(slot[head]));
        view.back_value  = VAL_W'($signed(slot[(head + held - 1) % DEPTH]));
        view.is_empty    = 1'b0;
      end
      view.count    = CNT_W'(held);
      view.rejected = rej;
      awaited.push_back(view);
    endfunction

    function void check_result(deque_view_t got);
      deque_view_t want;
      if (awaited.size() == 0) begin
        $error("result beat with no operation outstanding");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
        mismatches++;
      end
      if (got.back_value !== want.back_value) begin
        $error("back_value: expected %0d, got %0d", want.back_value, got.back_value);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dq_in_if  in_bus ();
  dq_out_if out_bus ();

  double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  deque_scoreboard sb = new();
  int  ops_sent;
  bit  no_gaps;   // source runs back to back for the current segment

  // 8 ns period
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Operation mix for free-running segments: mostly pushes and pops,
  // a sprinkle of clears and unused codes.
  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return FN_PUSH_FRONT;
    if (r < 56) return FN_PUSH_BACK;
    if (r < 76) return FN_POP_FRONT;
    if (r < 96) return FN_POP_BACK;
    if (r < 98) return FN_CLEAR;
    return FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
  endfunction

  // Offer one beat, hold it until taken, then maybe idle.
  task automatic send_op(logic [FUNC_W-1:0] fn, logic signed [VAL_W-1:0] v);
    int gap;
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.func  <= fn;
    in_bus.value <= v;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.apply_op(fn, v);
    ops_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic push_any(logic signed [VAL_W-1:0] v);
    send_op($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, v);
  endtask

  task automatic pop_any();
    send_op($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, $urandom);
  endtask

  // Stimulus
  initial begin : op_source
    int kind;
    int len;
    rst_ni       = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.func  = FN_PUSH_FRONT;
    in_bus.value = '0;
    ops_sent     = 0;
    no_gaps      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-queue rejects, no-ops, extremes, both ends.
    send_op(FN_POP_FRONT, $urandom);        // pop on empty
    send_op(FN_POP_BACK, $urandom);         // pop on empty
    send_op(FN_UNUSED_FIRST, $urandom);     // no-op on empty
    send_op(FN_CLEAR, $urandom);            // clear on empty
    send_op(FN_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(FN_PUSH_BACK, 32'sh8000_0000);
    send_op(FN_PUSH_FRONT, '0);
    send_op(FN_PUSH_BACK, -1);
    send_op(FN_UNUSED_LAST, $urandom);      // no-op with entries held
    send_op(FN_UNUSED_MID, $urandom);       // middle unused code
    send_op(FN_POP_FRONT, $urandom);
    send_op(FN_POP_BACK, $urandom);
    send_op(FN_PUSH_BACK, 1);
    send_op(FN_PUSH_FRONT, -2);
    send_op(FN_CLEAR, $urandom);            // clear with entries held
    send_op(FN_POP_BACK, $urandom);         // empty again after clear
    send_op(FN_PUSH_BACK, 32'sh5555_5555);
    send_op(FN_POP_FRONT, $urandom);        // back to empty
    send_op(FN_PUSH_FRONT, 32'shaaaa_aaaa);
    send_op(FN_PUSH_BACK, 32'sh5555_5555);
    send_op(FN_POP_BACK, $urandom);
    send_op(FN_POP_FRONT, $urandom);
    send_op(FN_POP_FRONT, $urandom);        // reject after draining

    // Random segments. The first one fills the queue so that push-on-full
    // is always covered; later ones pick fill, drain or a free mix.
    kind = 0;
    while (ops_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (kind < 2) begin
        while (sb.held < DEPTH) push_any($urandom);
        repeat ($urandom_range(1, 3)) push_any($urandom);  // rejected on full
      end else if (kind < 4) begin
        while (sb.held > 0) pop_any();
        repeat ($urandom_range(1, 2)) pop_any();           // rejected on empty
      end else begin
        len = $urandom_range(10, 40);
        repeat (len) send_op(pick_func(), $urandom);
      end
      kind = $urandom_range(0, 9);
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    // Wait for every result, then keep watching for anything unexpected.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result sink: check every taken beat, stall at random, and once hold
  // off long enough that the block backs up into its input.
  initial begin : result_sink
    int          stall_left;
    int          taken;
    bit          squeezed;
    deque_view_t got;
    stall_left    = 0;
    taken         = 0;
    squeezed      = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        got.front_value = out_bus.front_value;
        got.back_value  = out_bus.back_value;
        got.is_empty    = out_bus.is_empty;
        got.count       = out_bus.count;
        got.rejected    = out_bus.rejected;
        sb.check_result(got);
        taken++;
      end
      @(negedge clk_i);
      if (!squeezed && taken >= SQUEEZE_AT) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_LEN;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: too many cycles without a beat on either channel.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $error("no beat for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
